// File: rtl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// shared types, constants and helpers of the disk mean filter
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int RADIUS     = 4;
    localparam int SPAN       = 2 * RADIUS + 1;
    localparam int IDX_BITS   = 4;
    localparam int PIX_BITS   = 16;
    localparam int COL_BITS   = 10;
    localparam int ROW_BITS   = 10;
    localparam int DIM_BITS   = 11;
    localparam int SLOT_BITS  = 4;
    localparam int ADDR_BITS  = SLOT_BITS + COL_BITS;
    localparam int REACH_BITS = 5;
    localparam int SUM_BITS   = 23;
    localparam int CNT_BITS   = 7;
    localparam int QUO_BITS   = SUM_BITS + 8;
    localparam int MEAN_BITS  = 24;
    localparam int DIV_BITS   = 5;

    localparam logic [DIM_BITS-1:0] MAX_DIM = 11'd1024;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(SPAN - 1);

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_REACH  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [REACH_BITS-1:0] reach;
    } frame_cfg_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [PIX_BITS-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } job_t;

    // square of (idx - RADIUS) for a window index
    function automatic logic [REACH_BITS-1:0] offset_sq(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS-1:0] mag;
        mag = (idx >= IDX_BITS'(RADIUS)) ? idx - IDX_BITS'(RADIUS) : IDX_BITS'(RADIUS) - idx;
        return REACH_BITS'(mag) * REACH_BITS'(mag);
    endfunction

endpackage

// File: rtl/disk_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// disk_mean_filter_unit
// streaming disk mean filter over a raster frame, results as Q16.8 means
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result is the truncated mean of the
// in-frame neighbours within the configured disk (at most radius 4). The
// front takes one beat a cycle while its two-entry job queue has room; each
// result then passes through the back, which walks the 9x9 window through
// the single read port of the line store, sets up and runs a bit-serial
// divider, and takes the next job only when it is through with the last.
// Input is held off while the frame's last result is still being worked, so
// a new frame never overwrites rows that are still read.
module disk_mean_filter_unit
    import dmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [PIX_BITS-1:0]  pixel_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [MEAN_BITS-1:0] mean_value,
    output logic                 frame_end,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [DIM_BITS-1:0]  cfg_data
);

    frame_cfg_t           cfg;
    store_wr_t            store_wr;
    job_t                 job_in, job_head;
    logic                 job_push, job_pop, job_empty, job_full, last_done;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [PIX_BITS-1:0]  rd_data;

    dmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .pixel_value (pixel_value),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .store_wr    (store_wr),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full),
        .last_done   (last_done)
    );

    dmf_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .pop      (job_pop),
        .head     (job_head),
        .empty    (job_empty),
        .full     (job_full)
    );

    dmf_line_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .job_head   (job_head),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .empty      (empty),
        .pop        (pop),
        .mean_value (mean_value),
        .frame_end  (frame_end),
        .last_done  (last_done)
    );

endmodule

// File: rtl/dmf_line_store.sv
// ----------------------------------------------------------------------------
// dmf_line_store
// ring of recent rows, one write port from the front, one read port for the back
// ----------------------------------------------------------------------------
module dmf_line_store
    import dmf_pkg::*;
(
    input  logic                 clk,
    input  store_wr_t            wr,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [PIX_BITS-1:0]  rd_data
);

    logic [PIX_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dmf_job_queue.sv
// ----------------------------------------------------------------------------
// dmf_job_queue
// two-entry queue of pending result positions between front and back
// ----------------------------------------------------------------------------
module dmf_job_queue
    import dmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/dmf_front.sv
// ----------------------------------------------------------------------------
// dmf_front
// input beats, configuration, raster counters and decision of due results
// ----------------------------------------------------------------------------
module dmf_front
    import dmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [PIX_BITS-1:0]  pixel_value,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [DIM_BITS-1:0]  cfg_data,
    output frame_cfg_t           cfg,
    output store_wr_t            store_wr,
    output logic                 job_push,
    output job_t                 job,
    input  logic                 job_full,
    input  logic                 last_done
);

    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [REACH_BITS-1:0] reach_reg, reach_next;
    logic [DIM_BITS-1:0]   in_row_reg, in_row_next;
    logic [COL_BITS-1:0]   in_col_reg, in_col_next;
    logic [ROW_BITS-1:0]   out_row_reg, out_row_next;
    logic [COL_BITS-1:0]   out_col_reg, out_col_next;
    logic                  last_pending_reg, last_pending_next;

    logic [DIM_BITS-1:0]   eff_w, eff_h, w_m1, h_m1;
    logic                  accept, complete, store, wrap, due, last, cfg_hit;
    logic [DIM_BITS-1:0]   col_inc, row_a, ty_raw, tx_raw, ty, tx, oc_inc;
    logic [COL_BITS-1:0]   col_a;

    always_comb
    begin
        eff_w = (width_reg == '0) ? DIM_BITS'(1) : ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
        eff_h = (height_reg == '0) ? DIM_BITS'(1) :
                ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
        w_m1  = eff_w - DIM_BITS'(1);
        h_m1  = eff_h - DIM_BITS'(1);
    end

    assign full   = job_full || last_pending_reg;
    assign accept = push && !full;

    always_comb
    begin
        complete = (in_row_reg >= eff_h);
        store    = accept && (op == OP_PIXEL) && !complete;
        col_inc  = {1'b0, in_col_reg} + DIM_BITS'(1);
        wrap     = (col_inc >= eff_w);
        col_a    = store ? (wrap ? '0 : col_inc[COL_BITS-1:0]) : in_col_reg;
        row_a    = (store && wrap) ? in_row_reg + DIM_BITS'(1) : in_row_reg;
        ty_raw   = {1'b0, out_row_reg} + DIM_BITS'(RADIUS);
        tx_raw   = {1'b0, out_col_reg} + DIM_BITS'(RADIUS);
        ty       = (ty_raw > h_m1) ? h_m1 : ty_raw;
        tx       = (tx_raw > w_m1) ? w_m1 : tx_raw;
        due      = (row_a >= eff_h) || (row_a > ty) || ((row_a == ty) && ({1'b0, col_a} > tx));
        job_push = accept && due;
        last     = ({1'b0, out_row_reg} == h_m1) && ({1'b0, out_col_reg} == w_m1);
        oc_inc   = {1'b0, out_col_reg} + DIM_BITS'(1);
    end

    always_comb
    begin
        width_next        = width_reg;
        height_next       = height_reg;
        reach_next        = reach_reg;
        in_row_next       = in_row_reg;
        in_col_next       = in_col_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        last_pending_next = last_pending_reg;
        cfg_hit           = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:
                begin
                    width_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_HEIGHT:
                begin
                    height_next = cfg_data;
                    cfg_hit     = 1'b1;
                end
                CFG_REACH:
                begin
                    reach_next = cfg_data[REACH_BITS-1:0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        if (cfg_hit || (job_push && last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (accept)
        begin
            in_row_next = row_a;
            in_col_next = col_a;
            if (job_push)
            begin
                if (oc_inc >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_BITS'(1);
                end
                else
                begin
                    out_col_next = oc_inc[COL_BITS-1:0];
                end
            end
        end
        if (job_push && last)
        begin
            last_pending_next = 1'b1;
        end
        else if (last_done)
        begin
            last_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= MAX_DIM;
            height_reg       <= MAX_DIM;
            reach_reg        <= REACH_BITS'(4);
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            last_pending_reg <= 1'b0;
        end
        else
        begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            reach_reg        <= reach_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            last_pending_reg <= last_pending_next;
        end
    end

    assign cfg.width     = eff_w;
    assign cfg.height    = eff_h;
    assign cfg.reach     = reach_reg;
    assign store_wr.en   = store;
    assign store_wr.addr = {in_row_reg[SLOT_BITS-1:0], in_col_reg};
    assign store_wr.data = pixel_value;
    assign job.row       = out_row_reg;
    assign job.col       = out_col_reg;
    assign job.last      = last;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, in_col_reg} < eff_w)
        else $error("input column beyond frame width");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("job pushed into a full queue");

endmodule

// File: rtl/dmf_back.sv
// ----------------------------------------------------------------------------
// dmf_back
// walks the disk window of one position, sums in-frame neighbours, divides
// ----------------------------------------------------------------------------
module dmf_back
    import dmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  frame_cfg_t            cfg,
    input  job_t                  job_head,
    input  logic                  job_empty,
    output logic                  job_pop,
    output logic                  rd_en,
    output logic [ADDR_BITS-1:0]  rd_addr,
    input  logic [PIX_BITS-1:0]   rd_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [MEAN_BITS-1:0]  mean_value,
    output logic                  frame_end,
    output logic                  last_done
);

    back_state_t           state_reg, state_next;
    job_t                  job_reg;
    logic [IDX_BITS-1:0]   j_reg, k_reg;
    logic                  hit_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [QUO_BITS-1:0]   qd_reg;
    logic [CNT_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic                  res_valid_reg;
    logic [MEAN_BITS-1:0]  mean_reg;
    logic                  end_reg;

    logic                  scan_en, scan_last, load_res, div_last, hit, ge;
    logic signed [DIM_BITS:0] y, x;
    logic [REACH_BITS:0]   disk_sq;
    logic [CNT_BITS:0]     rem_shift;

    always_comb
    begin
        y         = $signed({2'b00, job_reg.row}) + $signed({{(DIM_BITS-IDX_BITS+1){1'b0}}, j_reg})
                    - (DIM_BITS+1)'(RADIUS);
        x         = $signed({2'b00, job_reg.col}) + $signed({{(DIM_BITS-IDX_BITS+1){1'b0}}, k_reg})
                    - (DIM_BITS+1)'(RADIUS);
        disk_sq   = {1'b0, offset_sq(j_reg)} + {1'b0, offset_sq(k_reg)};
        hit       = !y[DIM_BITS] && (y[DIM_BITS-1:0] < cfg.height) &&
                    !x[DIM_BITS] && (x[DIM_BITS-1:0] < cfg.width) &&
                    (disk_sq <= {1'b0, cfg.reach});
        scan_last = (j_reg == IDX_LAST) && (k_reg == IDX_LAST);
        div_last  = (div_reg == DIV_BITS'(QUO_BITS - 1));
        rem_shift = {rem_reg, qd_reg[QUO_BITS-1]};
        ge        = (rem_shift >= {1'b0, cnt_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = job_empty ? ST_IDLE : ST_SCAN;
            ST_SCAN:  state_next = scan_last ? ST_FLUSH : ST_SCAN;
            ST_FLUSH: state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:   state_next = div_last ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = (!res_valid_reg || pop) ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop  = 1'b0;
        scan_en  = 1'b0;
        load_res = 1'b0;
        case (state_reg)
            ST_IDLE: job_pop  = !job_empty;
            ST_SCAN: scan_en  = 1'b1;
            ST_DONE: load_res = !res_valid_reg || pop;
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    assign rd_en     = scan_en && hit;
    assign rd_addr   = {y[SLOT_BITS-1:0], x[COL_BITS-1:0]};
    assign last_done = load_res && job_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= scan_en && hit;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_head;
            j_reg   <= '0;
            k_reg   <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (scan_en)
            begin
                if (k_reg == IDX_LAST)
                begin
                    k_reg <= '0;
                    j_reg <= j_reg + IDX_BITS'(1);
                end
                else
                begin
                    k_reg <= k_reg + IDX_BITS'(1);
                end
            end
            if (hit_reg)
            begin
                sum_reg <= sum_reg + SUM_BITS'(rd_data);
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
        end
        if (state_reg == ST_PREP)
        begin
            qd_reg  <= {sum_reg, 8'b0};
            rem_reg <= '0;
            div_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            qd_reg  <= {qd_reg[QUO_BITS-2:0], ge};
            rem_reg <= ge ? CNT_BITS'(rem_shift - {1'b0, cnt_reg}) : rem_shift[CNT_BITS-1:0];
            div_reg <= div_reg + DIV_BITS'(1);
        end
        if (load_res)
        begin
            mean_reg <= (cnt_reg == '0) ? '0 : qd_reg[MEAN_BITS-1:0];
            end_reg  <= job_reg.last;
        end
    end

    assign empty      = !res_valid_reg;
    assign mean_value = mean_reg;
    assign frame_end  = end_reg;

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("dividing by an empty neighbour count");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN) || (state_reg == ST_FLUSH))
        else $error("window scan left early");

endmodule
